### design/mia_pkg.sv
// package: sizes, memory layout, operation codes and sigmoid table for the mlp block
`default_nettype none
package mia_pkg;
  localparam int INPUT_SIZE = 784;
  localparam int HIDDEN_ONE_SIZE = 100;
  localparam int HIDDEN_TWO_SIZE = 30;
  localparam int OUTPUT_SIZE = 10;
  localparam int W1_COUNT = HIDDEN_ONE_SIZE * INPUT_SIZE;
  localparam int W2_COUNT = HIDDEN_TWO_SIZE * HIDDEN_ONE_SIZE;
  localparam int W3_COUNT = OUTPUT_SIZE * HIDDEN_TWO_SIZE;
  localparam int WEIGHT_DEPTH = W1_COUNT + W2_COUNT + W3_COUNT;
  localparam int BIAS_DEPTH = HIDDEN_ONE_SIZE + HIDDEN_TWO_SIZE + OUTPUT_SIZE;
  localparam int ACT_DEPTH = HIDDEN_ONE_SIZE + HIDDEN_TWO_SIZE;
  localparam int WAW = $clog2(WEIGHT_DEPTH);
  localparam int BAW = $clog2(BIAS_DEPTH);
  localparam int HAW = $clog2(ACT_DEPTH);
  localparam int SAW = $clog2(HIDDEN_ONE_SIZE);
  localparam int PPW = $clog2(INPUT_SIZE + 1);

  localparam logic [1:0] OP_LOAD_WEIGHT = 2'd0;
  localparam logic [1:0] OP_LOAD_BIAS   = 2'd1;
  localparam logic [1:0] OP_PIXEL       = 2'd2;

  typedef logic signed [31:0] sum_t;

  function automatic sum_t sat_add(input sum_t a, input logic signed [40:0] b);
    logic signed [41:0] r;
    r = 42'(a) + 42'(b);
    if (r > 42'sd2147483647) sat_add = 32'sh7fffffff;
    else if (r < -42'sd2147483648) sat_add = 32'sh80000000;
    else sat_add = r[31:0];
  endfunction

  // shift and subtract quotient, used only while building the table
  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem = rem - den;
        quo[b] = 1'b1;
      end
    end
    udiv = quo;
  endfunction

  // sigmoid index k = 0..128, positive and negative halves
  function automatic logic [7:0] sig_lut(input logic [7:0] k, input logic neg);
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] a;
    e = 64'd1 << 30;
    for (int i = 0; i < 129; i++) begin
      if (i < int'(k)) e = (e * 64'd1008687096 + (64'd1 << 29)) >> 30;
    end
    d = (64'd1 << 30) + e;
    if (!neg) begin
      a = udiv((64'd1 << 38) + (d >> 1), d);
      sig_lut = (a > 64'd255) ? 8'd255 : a[7:0];
    end else begin
      a = udiv(64'd256 * e + (d >> 1), d);
      sig_lut = a[7:0];
    end
  endfunction

  typedef logic [7:0] lut_t [0:128];
  function automatic lut_t build_lut(input logic neg);
    lut_t t;
    for (int i = 0; i < 129; i++) t[i] = sig_lut(8'(i), neg);
    build_lut = t;
  endfunction
  localparam lut_t SIG_POS = build_lut(1'b0);
  localparam lut_t SIG_NEG = build_lut(1'b1);

  function automatic logic [7:0] sigmoid(input sum_t z);
    logic [31:0] m;
    logic [31:0] k;
    m = z[31] ? (32'd0 - 32'(z)) : 32'(z);
    k = (m + 32'd32768) >> 16;
    if (m >= (32'd8 << 20)) sigmoid = z[31] ? 8'd0 : 8'd255;
    else if (z[31]) sigmoid = SIG_NEG[k[7:0]];
    else sigmoid = SIG_POS[k[7:0]];
  endfunction
endpackage
`default_nettype wire

### design/mia_if.sv
// valid/ready channel interfaces for input and result beats
`default_nettype none
interface mia_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [16:0] address;
  logic signed [15:0] coefficient;
  logic [7:0]  pixel;
  logic [3:0]  label;
  logic        last_pixel;
  modport source (output valid, operation, address, coefficient, pixel, label, last_pixel,
                  input ready);
  modport sink (input valid, operation, address, coefficient, pixel, label, last_pixel,
                output ready);
endinterface

interface mia_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  predicted_class;
  logic        label_match;
  logic [15:0] correct_count;
  logic [15:0] sample_count;
  modport source (output valid, predicted_class, label_match, correct_count, sample_count,
                  input ready);
  modport sink (input valid, predicted_class, label_match, correct_count, sample_count,
                output ready);
endinterface
`default_nettype wire

### design/mlp_inference_argmax.sv
// top level: memory-based mlp inference with argmax classification
// channels: in_ (load weight, load bias, pixel beats) and out_ (one result per image).
// a load beat is written into the weight or bias memory. a pixel beat walks the 100
// first-layer neurons through one shared multiply-accumulate, reading weight and sum
// memories and writing the sum back. the last pixel then runs the classify sequence:
// 100 bias/sigmoid steps, 30x100 and 10x30 mac steps through the weight memory, and
// a 10-step argmax, then one result beat. the first-layer sums are cleared by the
// classify pass itself, so the next image starts from zero. after reset a clearing
// pass zeroes the sum memory while no beat is accepted; counters reset to zero.
// the result sits in an output register; when the receiver stalls the block holds
// it and accepts further load beats, and a pixel beat waits until the result is taken.
`default_nettype none
module mlp_inference_argmax import mia_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  mia_in_if.sink    in_ch,
  mia_out_if.source out_ch
);
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_L1    = 4'd2;
  localparam logic [3:0] S_H1    = 4'd3;
  localparam logic [3:0] S_L2    = 4'd4;
  localparam logic [3:0] S_L3    = 4'd5;
  localparam logic [3:0] S_ARG   = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  logic signed [15:0] wmem [0:WEIGHT_DEPTH-1];
  logic signed [15:0] bmem [0:BIAS_DEPTH-1];
  sum_t               smem [0:HIDDEN_ONE_SIZE-1];
  logic [7:0]         amem [0:ACT_DEPTH-1];
  sum_t               omem [0:OUTPUT_SIZE-1];

  logic [3:0]  state_r;
  logic [PPW-1:0] pos_r;
  logic [10:0] j_r;      // neuron index
  logic [10:0] i_r;      // input index, i_r == count means bias step
  logic [WAW-1:0] wa_r;
  logic        rv_r;     // a read issued last cycle
  logic [10:0] rj_r, ri_r;
  logic [7:0]  pix_r;
  logic [3:0]  label_r;
  sum_t        acc_r;
  logic signed [15:0] wq_r, bq_r;
  sum_t        sq_r;
  logic [7:0]  aq_r;
  sum_t        oq_r;
  sum_t        best_v_r;
  logic [3:0]  best_r;
  logic [15:0] match_cnt_r, img_cnt_r;
  logic        ov_r;
  logic [3:0]  oc_r;
  logic        om_r;

  logic acc_in;
  assign in_ch.ready = (state_r == S_IDLE) &&
                       !(in_ch.operation == OP_PIXEL && ov_r);
  assign acc_in = in_ch.valid && in_ch.ready;

  // loads and memory reads
  always_ff @(posedge clk) begin
    if (acc_in && in_ch.operation == OP_LOAD_WEIGHT && 32'(in_ch.address) < WEIGHT_DEPTH)
      wmem[in_ch.address[WAW-1:0]] <= in_ch.coefficient;
    if (acc_in && in_ch.operation == OP_LOAD_BIAS && 32'(in_ch.address) < BIAS_DEPTH)
      bmem[in_ch.address[BAW-1:0]] <= in_ch.coefficient;
    wq_r <= wmem[wa_r];
  end

  logic [BAW-1:0] ba;
  logic [SAW-1:0] sa;
  logic [HAW-1:0] ha;
  logic [3:0]     oa;
  always_comb begin
    ba = '0; sa = j_r[SAW-1:0]; ha = '0; oa = j_r[3:0];
    case (state_r)
      S_H1: ba = BAW'(j_r);
      S_L2: begin ba = BAW'(HIDDEN_ONE_SIZE + 32'(j_r)); ha = HAW'(i_r); end
      S_L3: begin
        ba = BAW'(HIDDEN_ONE_SIZE + HIDDEN_TWO_SIZE + 32'(j_r));
        ha = HAW'(HIDDEN_ONE_SIZE + 32'(i_r));
      end
      default: ;
    endcase
  end
  always_ff @(posedge clk) begin
    bq_r <= bmem[ba];
    sq_r <= smem[sa];
    aq_r <= amem[(ha < HAW'(ACT_DEPTH)) ? ha : '0];
    oq_r <= omem[oa];
  end

  // write path on the data returned in the cycle after the read
  logic signed [40:0] prod;
  sum_t s_new;
  always_comb begin
    prod = 41'(wq_r) * $signed({1'b0, (state_r == S_L1) ? pix_r : aq_r});
    s_new = sat_add(sq_r, prod);
  end
  always_ff @(posedge clk) begin
    if (state_r == S_CLR) smem[j_r[SAW-1:0]] <= '0;
    if (rv_r && state_r == S_L1) smem[rj_r[SAW-1:0]] <= s_new;
    if (rv_r && state_r == S_H1) begin
      amem[HAW'(rj_r)] <= sigmoid(sat_add(sq_r, 41'(bq_r) * 41'sd256));
      smem[rj_r[SAW-1:0]] <= '0;
    end
    if (rv_r && state_r == S_L2 && ri_r == 11'(HIDDEN_ONE_SIZE))
      amem[HAW'(HIDDEN_ONE_SIZE + 32'(rj_r))] <= sigmoid(sat_add(acc_r, 41'(bq_r) * 41'sd256));
    if (rv_r && state_r == S_L3 && ri_r == 11'(HIDDEN_TWO_SIZE))
      omem[rj_r[3:0]] <= sat_add(acc_r, 41'(bq_r) * 41'sd256);
  end

  // sequencer
  logic [10:0] cnt;
  always_comb begin
    case (state_r)
      S_L2: cnt = 11'(HIDDEN_ONE_SIZE);
      S_L3: cnt = 11'(HIDDEN_TWO_SIZE);
      default: cnt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; j_r <= '0; i_r <= '0; rv_r <= 1'b0; pos_r <= '0;
      match_cnt_r <= '0; img_cnt_r <= '0; ov_r <= 1'b0;
    end else begin
      rv_r <= 1'b0;
      rj_r <= j_r; ri_r <= i_r;
      if (out_ch.valid && out_ch.ready) ov_r <= 1'b0;
      case (state_r)
        S_CLR: begin
          j_r <= j_r + 11'd1;
          if (j_r == 11'(HIDDEN_ONE_SIZE - 1)) begin state_r <= S_IDLE; j_r <= '0; end
        end
        S_IDLE: if (acc_in && in_ch.operation == OP_PIXEL) begin
          pix_r <= in_ch.pixel; label_r <= in_ch.label; j_r <= '0; i_r <= '0;
          if (32'(pos_r) < INPUT_SIZE) begin
            pos_r <= pos_r + PPW'(1);
            state_r <= S_L1;
            wa_r <= WAW'(pos_r);
            i_r <= 11'(in_ch.last_pixel);
          end else if (in_ch.last_pixel) state_r <= S_H1;
        end
        S_L1: begin
          // j walks neurons; read at j, write back in the following cycle
          if (j_r < 11'(HIDDEN_ONE_SIZE)) begin
            rv_r <= 1'b1;
            j_r <= j_r + 11'd1;
            wa_r <= WAW'(32'(wa_r) + INPUT_SIZE);
          end else if (!rv_r) begin
            j_r <= '0;
            state_r <= i_r[0] ? S_H1 : S_IDLE;
            i_r <= '0;
          end
        end
        S_H1: begin
          if (j_r < 11'(HIDDEN_ONE_SIZE)) begin
            rv_r <= 1'b1; j_r <= j_r + 11'd1;
          end else if (!rv_r) begin
            j_r <= '0; i_r <= '0; state_r <= S_L2; acc_r <= '0;
            wa_r <= WAW'(W1_COUNT);
          end
        end
        S_L2, S_L3: begin
          // one read in flight at a time per neuron sum: read, then accumulate
          if (!rv_r) begin
            rv_r <= 1'b1;
          end else begin
            if (ri_r != cnt) acc_r <= sat_add(acc_r, prod);
            if (i_r == cnt) begin
              i_r <= '0; acc_r <= '0;
              if (j_r == 11'(state_r == S_L2 ? HIDDEN_TWO_SIZE - 1 : OUTPUT_SIZE - 1)) begin
                j_r <= '0;
                state_r <= (state_r == S_L2) ? S_L3 : S_ARG;
                wa_r <= WAW'(W1_COUNT + W2_COUNT);
              end else j_r <= j_r + 11'd1;
            end else begin
              i_r <= i_r + 11'd1;
              if (i_r + 11'd1 != cnt) wa_r <= wa_r + WAW'(1);
              else wa_r <= wa_r + WAW'(1);
            end
          end
        end
        S_ARG: begin
          if (!rv_r) rv_r <= 1'b1;
          else begin
            if (rj_r == '0 || oq_r > best_v_r) begin best_v_r <= oq_r; best_r <= rj_r[3:0]; end
            if (j_r == 11'(OUTPUT_SIZE - 1)) state_r <= S_DONE;
            else j_r <= j_r + 11'd1;
          end
        end
        S_DONE: begin
          oc_r <= best_r;
          om_r <= ({7'd0, best_r} == 11'(label_r));
          if ({7'd0, best_r} == 11'(label_r) && match_cnt_r != 16'hffff)
            match_cnt_r <= match_cnt_r + 16'd1;
          if (img_cnt_r != 16'hffff) img_cnt_r <= img_cnt_r + 16'd1;
          ov_r <= 1'b1;
          pos_r <= '0; j_r <= '0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.predicted_class = oc_r;
  assign out_ch.label_match = om_r;
  assign out_ch.correct_count = match_cnt_r;
  assign out_ch.sample_count = img_cnt_r;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_no_pixel_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && in_ch.operation == OP_PIXEL) |-> !in_ch.ready) else $error("pixel over result");
  a_cnt_order: assert property (@(posedge clk) disable iff (!rst_n)
    match_cnt_r <= img_cnt_r) else $error("matches exceed images");
endmodule
`default_nettype wire
